// File: src/smg_pkg.sv
// Shared types, widths, constants and helpers for the UV-sphere cell tessellator.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package smg_pkg;

   // field and datapath widths
   localparam int RADIUS_W = 31;
   localparam int COUNT_W  = 11;
   localparam int INDEX_W  = 10;
   localparam int COORD_W  = 32;
   localparam int VNUM_W   = 3;
   localparam int PHASE_W  = 32;
   localparam int TRIG_W   = 32;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   // 2*R*(i+1) + L/2 fits in 43 bits
   localparam int HNUM_W = 43;
   // k * 2^32, k below the slice count
   localparam int PNUM_W = COUNT_W + PHASE_W;
   localparam int Y_W    = HNUM_W + 2;
   localparam int SQ_W   = 2 * RADIUS_W;

   // CORDIC
   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_W     = 34;
   localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
   localparam logic [30:0] CORDIC_GAIN = 31'd652032874;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
      30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
      30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
      30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
      30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
      30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
      30'h0000001F, 30'h0000000F, 30'h00000007, 30'h00000003, 30'h00000001
   };

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // pipeline schedule, in stages after the input register
   localparam int TRIG_LAT = INDEX_W + PNUM_W + CORDIC_LAT;
   localparam int Q_STG    = 1 + HNUM_W;
   localparam int RING_STG = Q_STG + 3 + SQ_W / 2;
   localparam int Y_DLY    = TRIG_LAT - Q_STG;
   localparam int ROOT_DLY = TRIG_LAT - RING_STG;

   // register map
   localparam logic [1:0] REG_RADIUS = 2'd0;
   localparam logic [1:0] REG_SLICES = 2'd1;
   localparam logic [1:0] REG_LAYERS = 2'd2;

   localparam logic [RADIUS_W-1:0] RADIUS_RST = 31'd65536;
   localparam logic [COUNT_W-1:0]  SLICES_RST = 11'd16;
   localparam logic [COUNT_W-1:0]  LAYERS_RST = 11'd16;
   localparam logic [COUNT_W-1:0]  MIN_SLICES = 11'd3;
   localparam logic [COUNT_W-1:0]  MIN_LAYERS = 11'd1;
   localparam int DEF_MAX_SLICES = 1024;
   localparam int DEF_MAX_LAYERS = 1024;

   localparam logic [VNUM_W-1:0] LAST_VERTEX = 3'd5;

   typedef struct packed {
      logic signed [TRIG_W-1:0] cos1;
      logic signed [TRIG_W-1:0] sin1;
      logic signed [TRIG_W-1:0] cos2;
      logic signed [TRIG_W-1:0] sin2;
      logic [RADIUS_W-1:0]      ring1;
      logic [RADIUS_W-1:0]      ring2;
      logic signed [Y_W-1:0]    ylo;
      logic signed [Y_W-1:0]    yhi;
   } cell_type;

   typedef struct packed {
      logic alt_angle;   // angle of the next slice
      logic upper_ring;  // ring at the upper band edge
      logic upper_y;     // height of the upper band edge
      logic mirror;      // reflected across the equator
   } vsel_type;

   function automatic vsel_type vertex_sel(input logic [VNUM_W-1:0] n);
      vsel_type v;
      case (n)
         3'd0:    v = '{1'b1, 1'b0, 1'b0, 1'b0};
         3'd1:    v = '{1'b0, 1'b1, 1'b1, 1'b0};
         3'd2:    v = '{1'b1, 1'b1, 1'b1, 1'b0};
         3'd3:    v = '{1'b0, 1'b0, 1'b0, 1'b1};
         3'd4:    v = '{1'b1, 1'b1, 1'b1, 1'b1};
         3'd5:    v = '{1'b0, 1'b1, 1'b1, 1'b1};
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > 64'sd2147483647)
         r = 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648)
         r = 32'sh80000000;
      else
         r = COORD_W'(v);
      return r;
   endfunction

endpackage

`default_nettype wire

// File: src/smg_div.sv
// Pipelined restoring divider, one quotient bit per stage, constant divisor.
// Depends on nothing beyond its parameters.
`default_nettype none

module smg_div #(
   parameter int NW = 8,
   parameter int DW = 8
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [NW-1:0] quo,
   output logic [DW-1:0] rem
);

   logic [NW-1:0] nq_ff [NW];
   logic [NW-1:0] nq_in [NW];
   logic [DW-1:0] r_ff  [NW];
   logic [DW-1:0] r_in  [NW];

   always_comb begin
      logic [NW-1:0] ns;
      logic [DW-1:0] rs;
      logic [DW:0]   t;
      logic          ge;
      for (int s = 0; s < NW; s++) begin
         if (s == 0) begin
            ns = num;
            rs = '0;
         end else begin
            ns = nq_ff[s-1];
            rs = r_ff[s-1];
         end
         t  = {rs, ns[NW-1]};
         ge = (t >= {1'b0, den});
         r_in[s]  = ge ? DW'(t - {1'b0, den}) : DW'(t);
         nq_in[s] = {ns[NW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NW; s++) begin
            nq_ff[s] <= nq_in[s];
            r_ff[s]  <= r_in[s];
         end
      end
   end

   assign quo = nq_ff[NW-1];
   assign rem = r_ff[NW-1];

endmodule

`default_nettype wire

// File: src/smg_isqrt.sv
// Pipelined floor square root, one root bit per stage.
// Depends on nothing beyond its parameters.
`default_nettype none

module smg_isqrt #(
   parameter int W = 8
) (
   input  logic           clock,
   input  logic           en,
   input  logic [W-1:0]   arg,
   output logic [W/2-1:0] root
);

   localparam int OW = W / 2;

   logic [W-1:0] v_ff   [OW];
   logic [W-1:0] v_in   [OW];
   logic [W-1:0] res_ff [OW];
   logic [W-1:0] res_in [OW];

   always_comb begin
      logic [W-1:0] vs;
      logic [W-1:0] rs;
      logic [W-1:0] bt;
      logic [W:0]   sum;
      for (int s = 0; s < OW; s++) begin
         if (s == 0) begin
            vs = arg;
            rs = '0;
         end else begin
            vs = v_ff[s-1];
            rs = res_ff[s-1];
         end
         bt  = W'(1) << (2 * (OW - 1 - s));
         sum = (W+1)'(rs) + (W+1)'(bt);
         if ((W+1)'(vs) >= sum) begin
            v_in[s]   = vs - W'(sum);
            res_in[s] = (rs >> 1) + bt;
         end else begin
            v_in[s]   = vs;
            res_in[s] = rs >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < OW; s++) begin
            v_ff[s]   <= v_in[s];
            res_ff[s] <= res_in[s];
         end
      end
   end

   assign root = OW'(res_ff[OW-1]);

endmodule

`default_nettype wire

// File: src/smg_cordic.sv
// Pipelined CORDIC: turn fraction in, Q30 cosine and sine out.
// Depends on smg_pkg.
`default_nettype none

module smg_cordic (
   input  logic                                clock,
   input  logic                                en,
   input  logic [smg_pkg::PHASE_W-1:0]         phase,
   output logic signed [smg_pkg::TRIG_W-1:0]   cos_q30,
   output logic signed [smg_pkg::TRIG_W-1:0]   sin_q30
);

   localparam int CW = smg_pkg::CORDIC_W;
   localparam int N  = smg_pkg::CORDIC_STEPS;
   localparam int ZP_W = 61;

   logic [1:0]            quad0_ff;
   logic [ZP_W-1:0]       zp_ff;
   logic signed [CW-1:0]  x_ff [N];
   logic signed [CW-1:0]  y_ff [N];
   logic signed [CW-1:0]  z_ff [N];
   logic [1:0]            quad_ff [N];
   logic signed [CW-1:0]  x_in [N];
   logic signed [CW-1:0]  y_in [N];
   logic signed [CW-1:0]  z_in [N];
   logic signed [smg_pkg::TRIG_W-1:0] cos_ff, sin_ff, cos_in, sin_in;

   always_comb begin
      logic signed [CW-1:0] xs, ys, zs, at;
      for (int i = 0; i < N; i++) begin
         if (i == 0) begin
            xs = CW'(smg_pkg::CORDIC_GAIN);
            ys = '0;
            zs = CW'(zp_ff >> 30);
         end else begin
            xs = x_ff[i-1];
            ys = y_ff[i-1];
            zs = z_ff[i-1];
         end
         at = CW'(smg_pkg::ATAN_Q30[i]);
         if (!zs[CW-1]) begin
            x_in[i] = xs - (ys >>> i);
            y_in[i] = ys + (xs >>> i);
            z_in[i] = zs - at;
         end else begin
            x_in[i] = xs + (ys >>> i);
            y_in[i] = ys - (xs >>> i);
            z_in[i] = zs + at;
         end
      end
   end

   // quadrant rotation
   always_comb begin
      case (quad_ff[N-1])
         smg_pkg::QUAD_0: begin
            cos_in = smg_pkg::TRIG_W'(x_ff[N-1]);
            sin_in = smg_pkg::TRIG_W'(y_ff[N-1]);
         end
         smg_pkg::QUAD_1: begin
            cos_in = smg_pkg::TRIG_W'(-y_ff[N-1]);
            sin_in = smg_pkg::TRIG_W'(x_ff[N-1]);
         end
         smg_pkg::QUAD_2: begin
            cos_in = smg_pkg::TRIG_W'(-x_ff[N-1]);
            sin_in = smg_pkg::TRIG_W'(-y_ff[N-1]);
         end
         default: begin
            cos_in = smg_pkg::TRIG_W'(y_ff[N-1]);
            sin_in = smg_pkg::TRIG_W'(-x_ff[N-1]);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quad0_ff <= phase[31:30];
         zp_ff    <= ZP_W'(phase[29:0]) * ZP_W'(smg_pkg::HALF_PI_Q30);
         for (int i = 0; i < N; i++) begin
            x_ff[i]    <= x_in[i];
            y_ff[i]    <= y_in[i];
            z_ff[i]    <= z_in[i];
            quad_ff[i] <= (i == 0) ? quad0_ff : quad_ff[(i == 0) ? 0 : i-1];
         end
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_q30 = cos_ff;
   assign sin_q30 = sin_ff;

endmodule

`default_nettype wire

// File: src/smg_emit.sv
// Vertex sequencer: holds one finished cell, scales trig by ring radius per vertex,
// and drives the result channel through a product stage and an output register.
// Depends on smg_pkg.
`default_nettype none

module smg_emit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cell_valid,
   input  smg_pkg::cell_type                   cell_data,
   output logic                                cell_take,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [smg_pkg::COORD_W-1:0]  rsp_vertex_x,
   output logic signed [smg_pkg::COORD_W-1:0]  rsp_vertex_y,
   output logic signed [smg_pkg::COORD_W-1:0]  rsp_vertex_z,
   output logic [smg_pkg::VNUM_W-1:0]          rsp_vertex_number,
   output logic                                rsp_last_vertex
);

   smg_pkg::cell_type cell_ff;
   logic cell_vld_ff;
   logic [smg_pkg::VNUM_W-1:0] cnt_ff;

   logic m_vld_ff;
   logic signed [63:0] px_ff, pz_ff, px_in, pz_in;
   logic signed [smg_pkg::COORD_W-1:0] py_ff, py_in;
   logic [smg_pkg::VNUM_W-1:0] mnum_ff;

   logic rsp_valid_ff;
   logic signed [smg_pkg::COORD_W-1:0] x_ff, y_ff, z_ff;
   logic [smg_pkg::VNUM_W-1:0] num_ff;

   logic out_adv, m_adv, issue;
   smg_pkg::vsel_type sel;
   logic signed [smg_pkg::TRIG_W-1:0] tc, ts;
   logic signed [smg_pkg::COORD_W-1:0] rad;
   logic signed [smg_pkg::Y_W-1:0] ysel, yv;

   assign out_adv   = !rsp_valid_ff || !rsp_stall;
   assign m_adv     = !m_vld_ff || out_adv;
   assign issue     = cell_vld_ff && m_adv;
   assign cell_take = !cell_vld_ff || (m_adv && (cnt_ff == smg_pkg::LAST_VERTEX));

   always_comb begin
      sel   = smg_pkg::vertex_sel(cnt_ff);
      tc    = sel.alt_angle ? cell_ff.cos2 : cell_ff.cos1;
      ts    = sel.alt_angle ? cell_ff.sin2 : cell_ff.sin1;
      rad   = {1'b0, (sel.upper_ring ? cell_ff.ring2 : cell_ff.ring1)};
      ysel  = sel.upper_y ? cell_ff.yhi : cell_ff.ylo;
      yv    = sel.mirror ? -ysel : ysel;
      px_in = tc * rad;
      pz_in = ts * rad;
      py_in = smg_pkg::sat32(64'(yv));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_vld_ff  <= 1'b0;
         cnt_ff       <= '0;
         m_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cell_take)
            cell_vld_ff <= cell_valid;
         if (cell_take)
            cnt_ff <= '0;
         else if (issue)
            cnt_ff <= cnt_ff + 1'b1;
         if (m_adv)
            m_vld_ff <= issue;
         if (out_adv)
            rsp_valid_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cell_take)
         cell_ff <= cell_data;
      if (issue) begin
         px_ff   <= px_in;
         pz_ff   <= pz_in;
         py_ff   <= py_in;
         mnum_ff <= cnt_ff;
      end
      if (out_adv && m_vld_ff) begin
         x_ff   <= smg_pkg::sat32((px_ff + 64'sd536870912) >>> 30);
         z_ff   <= smg_pkg::sat32((pz_ff + 64'sd536870912) >>> 30);
         y_ff   <= py_ff;
         num_ff <= mnum_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vertex_x      = x_ff;
   assign rsp_vertex_y      = y_ff;
   assign rsp_vertex_z      = z_ff;
   assign rsp_vertex_number = num_ff;
   assign rsp_last_vertex   = (num_ff == smg_pkg::LAST_VERTEX);

endmodule

`default_nettype wire

// File: src/sphere_mesh_generator.sv
// UV-sphere cell tessellator: one (layer, slice) cell in, six Q16.16 vertices out.
// Depends on smg_pkg, smg_div, smg_isqrt, smg_cordic and smg_emit.
//
// A cell enters on the req_ channel and its six vertices leave one per cycle, while
// rsp_stall is low, on the rsp_ channel (vertex_number 0..5, last_vertex on the sixth):
// the rising-band triangle, then its mirror across the equator. The core is
// an 86-stage pipeline that takes a cell every cycle unless held; the single result port
// emits six vertices per cell, so the core waits on the vertex output. When the vertex
// sequencer is still busy with a cell, the whole pipeline holds and req_stall is raised.
// Radius, slice count and layer count are set over the APB-style port (byte addresses
// 0, 4, 8) and must only be changed while no transaction is in flight.
`default_nettype none

module sphere_mesh_generator #(
   parameter int MAX_SLICES = smg_pkg::DEF_MAX_SLICES,
   parameter int MAX_LAYERS = smg_pkg::DEF_MAX_LAYERS
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [smg_pkg::ADDR_W-1:0]          paddr,
   input  logic [smg_pkg::DATA_W-1:0]          pwdata,
   output logic [smg_pkg::DATA_W-1:0]          prdata,
   output logic                                pready,
   // cell input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [smg_pkg::INDEX_W-1:0]         req_layer_index,
   input  logic [smg_pkg::INDEX_W-1:0]         req_slice_index,
   // vertex output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [smg_pkg::COORD_W-1:0]  rsp_vertex_x,
   output logic signed [smg_pkg::COORD_W-1:0]  rsp_vertex_y,
   output logic signed [smg_pkg::COORD_W-1:0]  rsp_vertex_z,
   output logic [smg_pkg::VNUM_W-1:0]          rsp_vertex_number,
   output logic                                rsp_last_vertex
);

   localparam int RW = smg_pkg::RADIUS_W;
   localparam int CNW = smg_pkg::COUNT_W;
   localparam int YW = smg_pkg::Y_W;
   localparam int SQW = smg_pkg::SQ_W;
   localparam int TL = smg_pkg::TRIG_LAT;

   // ---------------- configuration registers ----------------
   logic [RW-1:0]  radius_ff;
   logic [CNW-1:0] slices_ff, layers_ff;
   logic [CNW-1:0] s_eff, l_eff;
   logic [1:0]     reg_idx;

   assign reg_idx = paddr[3:2];
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= smg_pkg::RADIUS_RST;
         slices_ff <= smg_pkg::SLICES_RST;
         layers_ff <= smg_pkg::LAYERS_RST;
      end else if (psel && penable && pwrite) begin
         case (reg_idx)
            smg_pkg::REG_RADIUS: radius_ff <= pwdata[RW-1:0];
            smg_pkg::REG_SLICES: slices_ff <= pwdata[CNW-1:0];
            smg_pkg::REG_LAYERS: layers_ff <= pwdata[CNW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         smg_pkg::REG_RADIUS: prdata = smg_pkg::DATA_W'(radius_ff);
         smg_pkg::REG_SLICES: prdata = smg_pkg::DATA_W'(slices_ff);
         smg_pkg::REG_LAYERS: prdata = smg_pkg::DATA_W'(layers_ff);
         default:             prdata = '0;
      endcase
   end

   // Clamp counts to legal range. Unenforced: the user keeps config static while cells are in flight.
   always_comb begin
      if (slices_ff < smg_pkg::MIN_SLICES)
         s_eff = smg_pkg::MIN_SLICES;
      else if (32'(slices_ff) > MAX_SLICES)
         s_eff = CNW'(MAX_SLICES);
      else
         s_eff = slices_ff;
      if (layers_ff < smg_pkg::MIN_LAYERS)
         l_eff = smg_pkg::MIN_LAYERS;
      else if (32'(layers_ff) > MAX_LAYERS)
         l_eff = CNW'(MAX_LAYERS);
      else
         l_eff = layers_ff;
   end

   // ---------------- pipeline control ----------------
   // One enable for every stage: the pipe moves only when the sequencer can take a cell.
   logic en;
   logic vld_ff [TL+1];

   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= TL; i++)
            vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i <= TL; i++)
            vld_ff[i] <= vld_ff[i-1];
      end
   end

   // stage 0: input register
   logic [smg_pkg::INDEX_W-1:0] li_ff, sj_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         li_ff <= req_layer_index;
         sj_ff <= req_slice_index;
      end
   end

   // ---------------- band heights and ring radii ----------------
   // stage 1: numerators 2*R*i + L/2 for the lower and upper band edge
   logic [CNW-1:0] ilo, ihi;
   logic [smg_pkg::HNUM_W-1:0] hnum_lo_ff, hnum_hi_ff, q_lo, q_hi;

   assign ilo = CNW'(li_ff);
   assign ihi = ilo + 1'b1;

   always_ff @(posedge clock) begin
      if (en) begin
         hnum_lo_ff <= ((smg_pkg::HNUM_W'(radius_ff) * smg_pkg::HNUM_W'(ilo)) << 1)
                       + smg_pkg::HNUM_W'(l_eff >> 1);
         hnum_hi_ff <= ((smg_pkg::HNUM_W'(radius_ff) * smg_pkg::HNUM_W'(ihi)) << 1)
                       + smg_pkg::HNUM_W'(l_eff >> 1);
      end
   end

   smg_div #(.NW(smg_pkg::HNUM_W), .DW(CNW)) u_hdiv_lo (
      .clock(clock), .en(en), .num(hnum_lo_ff), .den(l_eff), .quo(q_lo), .rem()
   );
   smg_div #(.NW(smg_pkg::HNUM_W), .DW(CNW)) u_hdiv_hi (
      .clock(clock), .en(en), .num(hnum_hi_ff), .den(l_eff), .quo(q_hi), .rem()
   );

   // height y = q - R, and whether the band lies outside the sphere
   logic signed [YW-1:0] y_lo, y_hi;
   logic [YW-1:0] ay_lo, ay_hi;

   always_comb begin
      y_lo  = signed'(YW'(q_lo)) - signed'(YW'(radius_ff));
      y_hi  = signed'(YW'(q_hi)) - signed'(YW'(radius_ff));
      ay_lo = y_lo[YW-1] ? YW'(-y_lo) : YW'(y_lo);
      ay_hi = y_hi[YW-1] ? YW'(-y_hi) : YW'(y_hi);
   end

   logic signed [YW-1:0] ylo_dly_ff [smg_pkg::Y_DLY];
   logic signed [YW-1:0] yhi_dly_ff [smg_pkg::Y_DLY];
   logic [RW-1:0]  ay_lo_ff, ay_hi_ff;
   logic           out_lo_ff, out_hi_ff, out_lo2_ff, out_hi2_ff;
   logic [SQW-1:0] rr_ff, aa_lo_ff, aa_hi_ff, arg_lo_ff, arg_hi_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ylo_dly_ff[0] <= y_lo;
         yhi_dly_ff[0] <= y_hi;
         for (int i = 1; i < smg_pkg::Y_DLY; i++) begin
            ylo_dly_ff[i] <= ylo_dly_ff[i-1];
            yhi_dly_ff[i] <= yhi_dly_ff[i-1];
         end
         ay_lo_ff   <= ay_lo[RW-1:0];
         ay_hi_ff   <= ay_hi[RW-1:0];
         out_lo_ff  <= (ay_lo >= YW'(radius_ff));
         out_hi_ff  <= (ay_hi >= YW'(radius_ff));
         // squares
         rr_ff      <= SQW'(radius_ff) * SQW'(radius_ff);
         aa_lo_ff   <= SQW'(ay_lo_ff) * SQW'(ay_lo_ff);
         aa_hi_ff   <= SQW'(ay_hi_ff) * SQW'(ay_hi_ff);
         out_lo2_ff <= out_lo_ff;
         out_hi2_ff <= out_hi_ff;
         // root argument R^2 - y^2, zero outside the sphere
         arg_lo_ff  <= out_lo2_ff ? '0 : rr_ff - aa_lo_ff;
         arg_hi_ff  <= out_hi2_ff ? '0 : rr_ff - aa_hi_ff;
      end
   end

   logic [RW-1:0] root_lo, root_hi;
   logic [RW-1:0] rlo_dly_ff [smg_pkg::ROOT_DLY];
   logic [RW-1:0] rhi_dly_ff [smg_pkg::ROOT_DLY];

   smg_isqrt #(.W(SQW)) u_sqrt_lo (
      .clock(clock), .en(en), .arg(arg_lo_ff), .root(root_lo)
   );
   smg_isqrt #(.W(SQW)) u_sqrt_hi (
      .clock(clock), .en(en), .arg(arg_hi_ff), .root(root_hi)
   );

   // align ring radii with the trig path
   always_ff @(posedge clock) begin
      if (en) begin
         rlo_dly_ff[0] <= root_lo;
         rhi_dly_ff[0] <= root_hi;
         for (int i = 1; i < smg_pkg::ROOT_DLY; i++) begin
            rlo_dly_ff[i] <= rlo_dly_ff[i-1];
            rhi_dly_ff[i] <= rhi_dly_ff[i-1];
         end
      end
   end

   // ---------------- slice angles ----------------
   logic [CNW-1:0] k1, k1p, k2;
   logic [smg_pkg::PNUM_W-1:0] ph1, ph2;
   logic signed [smg_pkg::TRIG_W-1:0] c1, s1, c2, s2;

   // slice index wraps modulo S
   smg_div #(.NW(smg_pkg::INDEX_W), .DW(CNW)) u_mod (
      .clock(clock), .en(en), .num(sj_ff), .den(s_eff), .quo(), .rem(k1)
   );

   assign k1p = k1 + 1'b1;
   assign k2  = (k1p == s_eff) ? '0 : k1p;

   // phase = floor(k * 2^32 / S), a fraction of a turn
   smg_div #(.NW(smg_pkg::PNUM_W), .DW(CNW)) u_pdiv1 (
      .clock(clock), .en(en), .num({k1, {smg_pkg::PHASE_W{1'b0}}}), .den(s_eff),
      .quo(ph1), .rem()
   );
   smg_div #(.NW(smg_pkg::PNUM_W), .DW(CNW)) u_pdiv2 (
      .clock(clock), .en(en), .num({k2, {smg_pkg::PHASE_W{1'b0}}}), .den(s_eff),
      .quo(ph2), .rem()
   );

   smg_cordic u_cordic1 (
      .clock(clock), .en(en), .phase(ph1[smg_pkg::PHASE_W-1:0]),
      .cos_q30(c1), .sin_q30(s1)
   );
   smg_cordic u_cordic2 (
      .clock(clock), .en(en), .phase(ph2[smg_pkg::PHASE_W-1:0]),
      .cos_q30(c2), .sin_q30(s2)
   );

   // ---------------- vertex sequencer ----------------
   smg_pkg::cell_type cell_data;

   always_comb begin
      cell_data.cos1  = c1;
      cell_data.sin1  = s1;
      cell_data.cos2  = c2;
      cell_data.sin2  = s2;
      cell_data.ring1 = rlo_dly_ff[smg_pkg::ROOT_DLY-1];
      cell_data.ring2 = rhi_dly_ff[smg_pkg::ROOT_DLY-1];
      cell_data.ylo   = ylo_dly_ff[smg_pkg::Y_DLY-1];
      cell_data.yhi   = yhi_dly_ff[smg_pkg::Y_DLY-1];
   end

   smg_emit u_emit (
      .clock(clock),
      .reset(reset),
      .cell_valid(vld_ff[TL]),
      .cell_data(cell_data),
      .cell_take(en),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_vertex_x(rsp_vertex_x),
      .rsp_vertex_y(rsp_vertex_y),
      .rsp_vertex_z(rsp_vertex_z),
      .rsp_vertex_number(rsp_vertex_number),
      .rsp_last_vertex(rsp_last_vertex)
   );

   // ---------------- checks ----------------
   // last flag marks exactly the sixth vertex
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_vertex == (rsp_vertex_number == smg_pkg::LAST_VERTEX)))
      else $error("last_vertex does not match vertex_number");

   // within a cell, vertices follow each other with no gap
   a_vertex_seq: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_vertex) |=>
         (rsp_valid && (rsp_vertex_number == $past(rsp_vertex_number) + 3'd1)))
      else $error("vertex sequence broken");

   // a cell's first vertex is the only one that may follow an idle cycle
   a_first_after_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> (rsp_vertex_number == '0))
      else $error("cell started mid sequence");

endmodule

`default_nettype wire
